// ===== hdl/frame_fifo_drop_oldest_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the frame queue
// Each macro names the clock and reset of the module that uses it.
// ----------------------------------------------------------------------------
`ifndef FRAME_FIFO_DROP_OLDEST_DEFINES_SVH
`define FRAME_FIFO_DROP_OLDEST_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define FFDO_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame queue check failed");

// Consequent must hold in the cycle after the antecedent
`define FFDO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame queue check failed");

`endif

// ===== hdl/ffdo_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffdo_pkg
// Command codes, register indexes and the status bundle of the frame queue.
// ----------------------------------------------------------------------------
package ffdo_pkg;

    // Commands
    localparam logic [1:0] CMD_PUSH  = 2'd0;
    localparam logic [1:0] CMD_POP   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic REG_SLOT_COUNT  = 1'b0;
    localparam logic REG_DROP_OLDEST = 1'b1;

    localparam int CFG_DATA_W = 9;
    localparam int OCC_W      = 8;
    localparam int FRAME_W    = 32;

    // Status of one finished command, valid while done is high
    typedef struct packed {
        logic             done;
        logic             success;
        logic             pop;
        logic             dropped;
        logic [OCC_W-1:0] occupancy;
        logic             is_empty;
        logic             is_full;
    } result_t;

endpackage

// ===== hdl/ffdo_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffdo_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ffdo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/ffdo_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffdo_ctrl
// Pointer logic: decode a command, move the ring pointers, drive the frame
// store write and report status in the next cycle.
// ----------------------------------------------------------------------------
module ffdo_ctrl #(
    parameter int MAX_SLOTS = 256,
    parameter int PW        = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             accept,
    input  logic [1:0]                       command,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [ffdo_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             mem_we,
    output logic [PW-1:0]                    mem_waddr,
    output logic [PW-1:0]                    mem_raddr,
    output ffdo_pkg::result_t                result
);

    localparam int CW         = (PW + 1 > ffdo_pkg::CFG_DATA_W + 1) ? PW + 1
                                                                    : ffdo_pkg::CFG_DATA_W + 1;
    localparam int RESET_RING = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;

    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [PW-1:0] ring_last_reg, ring_last_next;
    logic          drop_oldest_reg, drop_oldest_next;
    logic          done_reg, success_reg, pop_reg, dropped_reg;
    logic          success_next, pop_next, dropped_next;
    logic [CW-1:0] slots;
    logic [PW-1:0] wp_adv;
    logic [PW:0]   held;

    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p,
                                              input logic [PW-1:0] last);
        advance = (p == last) ? '0 : p + 1'b1;
    endfunction

    // Clamp the ring size written to slot_count into 2..MAX_SLOTS
    always_comb
    begin
        slots = CW'(cfg_data);
        if (slots < CW'(2))
        begin
            slots = CW'(2);
        end
        else if (slots > CW'(MAX_SLOTS))
        begin
            slots = CW'(MAX_SLOTS);
        end
    end

    assign wp_adv = advance(wp_reg, ring_last_reg);

    // Decode the command and advance the pointers
    always_comb
    begin
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        ring_last_next   = ring_last_reg;
        drop_oldest_next = drop_oldest_reg;
        success_next     = 1'b0;
        pop_next         = 1'b0;
        dropped_next     = 1'b0;
        mem_we           = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                ffdo_pkg::REG_SLOT_COUNT:
                begin
                    ring_last_next = PW'(slots - CW'(1));
                    wp_next        = '0;
                    rp_next        = '0;
                end
                ffdo_pkg::REG_DROP_OLDEST:
                begin
                    drop_oldest_next = cfg_data[0];
                end
                default:
                begin
                    drop_oldest_next = drop_oldest_reg;
                end
            endcase
        end
        else if (accept)
        begin
            unique case (command)
                ffdo_pkg::CMD_PUSH:
                begin
                    if (wp_adv != rp_reg)
                    begin
                        mem_we       = 1'b1;
                        wp_next      = wp_adv;
                        success_next = 1'b1;
                    end
                    else if (drop_oldest_reg)
                    begin
                        // Full: drop the oldest frame, then store
                        rp_next      = advance(rp_reg, ring_last_reg);
                        mem_we       = 1'b1;
                        wp_next      = wp_adv;
                        success_next = 1'b1;
                        dropped_next = 1'b1;
                    end
                end
                ffdo_pkg::CMD_POP:
                begin
                    if (wp_reg != rp_reg)
                    begin
                        rp_next      = advance(rp_reg, ring_last_reg);
                        success_next = 1'b1;
                        pop_next     = 1'b1;
                    end
                end
                default:
                begin
                    // Query and the unused code: status only
                    success_next = 1'b0;
                end
            endcase
        end
    end

    assign mem_waddr = wp_reg;
    assign mem_raddr = rp_reg;

    // Hold pointers, policy and the per-beat flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg          <= '0;
            rp_reg          <= '0;
            ring_last_reg   <= PW'(RESET_RING - 1);
            drop_oldest_reg <= 1'b0;
            done_reg        <= 1'b0;
            success_reg     <= 1'b0;
            pop_reg         <= 1'b0;
            dropped_reg     <= 1'b0;
        end
        else
        begin
            wp_reg          <= wp_next;
            rp_reg          <= rp_next;
            ring_last_reg   <= ring_last_next;
            drop_oldest_reg <= drop_oldest_next;
            done_reg        <= accept && !cfg_we;
            success_reg     <= success_next;
            pop_reg         <= pop_next;
            dropped_reg     <= dropped_next;
        end
    end

    // Status after the operation comes straight from the updated pointers
    always_comb
    begin
        if (wp_reg >= rp_reg)
        begin
            held = {1'b0, wp_reg} - {1'b0, rp_reg};
        end
        else
        begin
            held = {1'b0, wp_reg} + {1'b0, ring_last_reg - rp_reg} + (PW+1)'(1);
        end
    end

    always_comb
    begin
        result.done      = done_reg;
        result.success   = success_reg;
        result.pop       = pop_reg;
        result.dropped   = dropped_reg;
        result.occupancy = (32'(held) > 32'd255) ? 8'hFF : ffdo_pkg::OCC_W'(held);
        result.is_empty  = (wp_reg == rp_reg);
        result.is_full   = (wp_adv == rp_reg);
    end

endmodule

// ===== hdl/frame_fifo_drop_oldest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_fifo_drop_oldest
// Circular frame queue with a configurable ring size and a drop-oldest policy.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+----------------------------------------
//  command   | start, busy        | command, frame_in
//  result    | done (1 cycle)     | success, frame_out, dropped, occupancy,
//            |                    | is_empty, is_full
//  config    | cfg_we             | cfg_index, cfg_data
//
//  One command per cycle while cfg_we is low; busy stays low. A result beat
//  follows in the cycle after its command, as the store read is registered.
//  Reset empties the queue, sets the ring to 256 slots (or MAX_SLOTS if less)
//  and rejects pushes to a full queue. The frame store is not cleared.
//  The result side cannot stall: each beat is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`include "frame_fifo_drop_oldest_defines.svh"

module frame_fifo_drop_oldest #(
    parameter int MAX_SLOTS   = 256,
    parameter int FRAME_BYTES = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [1:0]                           command,
    input  logic [ffdo_pkg::FRAME_W-1:0]         frame_in,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [ffdo_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                 done,
    output logic                                 success,
    output logic [ffdo_pkg::FRAME_W-1:0]         frame_out,
    output logic                                 dropped,
    output logic [ffdo_pkg::OCC_W-1:0]           occupancy,
    output logic                                 is_empty,
    output logic                                 is_full
);

    localparam int PW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int FW = 8 * FRAME_BYTES;

    logic              accept;
    logic              mem_we;
    logic [PW-1:0]     mem_waddr;
    logic [PW-1:0]     mem_raddr;
    logic [FW-1:0]     mem_rdata;
    ffdo_pkg::result_t result;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    ffdo_ctrl #(
        .MAX_SLOTS (MAX_SLOTS),
        .PW        (PW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (command),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_raddr (mem_raddr),
        .result    (result)
    );

    // Frame store: keep the low frame bytes of each pushed word
    ffdo_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (FW'(frame_in)),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Drive the result beat; frame only on a successful pop
    assign done      = result.done;
    assign success   = result.success;
    assign frame_out = result.pop ? ffdo_pkg::FRAME_W'(mem_rdata) : '0;
    assign dropped   = result.dropped;
    assign occupancy = result.occupancy;
    assign is_empty  = result.is_empty;
    assign is_full   = result.is_full;

    // Checks
    `FFDO_ASSERT_NEXT(a_done_follows, accept && !cfg_we, done)
    `FFDO_ASSERT_NEXT(a_pop_nonempty, accept && !cfg_we && (command == ffdo_pkg::CMD_POP) && !is_empty && !done, success)
    `FFDO_ASSERT_SAME(a_drop_needs_full, done && dropped, success && is_full)
    `FFDO_ASSERT_SAME(a_not_both, done, !(is_empty && is_full))

endmodule

// ===== tb/frame_fifo_drop_oldest_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_fifo_drop_oldest_tb
// Drives push, pop and query commands into the frame queue under changing
// ring sizes and full policies. Each status beat is checked against a table
// expectation or an in-bench queue model. A short directed table comes
// first: reset state, extreme frames, reject and drop on full, the unused
// command code and out-of-range ring sizes. Random bursty phases follow.
// ----------------------------------------------------------------------------
module frame_fifo_drop_oldest_tb;

    localparam int MAX_SLOTS     = 256;
    localparam int FRAME_BYTES   = 4;
    localparam int RAND_ITEMS    = 1750;
    localparam int MAX_ERR_LINES = 100;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam logic [63:0] FRAME_MASK =
        (FRAME_BYTES >= 8) ? '1 : ((64'd1 << (8 * FRAME_BYTES)) - 64'd1);

    // Status of one command as the queue reports it
    typedef struct packed {
        logic                         success;
        logic [ffdo_pkg::FRAME_W-1:0] frame;
        logic                         dropped;
        logic [ffdo_pkg::OCC_W-1:0]   occupancy;
        logic                         is_empty;
        logic                         is_full;
    } status_t;

    typedef enum logic [1:0] {ROW_CMD, ROW_TYPED, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [1:0]                      cmd;
        logic [ffdo_pkg::FRAME_W-1:0]    frame;
        logic                            reg_index;
        logic [ffdo_pkg::CFG_DATA_W-1:0] reg_value;
        status_t                         want;
    } stim_row_t;

    logic                            clk;
    logic                            rst_n;
    logic                            start;
    logic                            busy;
    logic [1:0]                      command;
    logic [ffdo_pkg::FRAME_W-1:0]    frame_in;
    logic                            cfg_we;
    logic                            cfg_index;
    logic [ffdo_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            done;
    logic                            success;
    logic [ffdo_pkg::FRAME_W-1:0]    frame_out;
    logic                            dropped;
    logic [ffdo_pkg::OCC_W-1:0]      occupancy;
    logic                            is_empty;
    logic                            is_full;

    frame_fifo_drop_oldest #(
        .MAX_SLOTS   (MAX_SLOTS),
        .FRAME_BYTES (FRAME_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .command   (command),
        .frame_in  (frame_in),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .done      (done),
        .success   (success),
        .frame_out (frame_out),
        .dropped   (dropped),
        .occupancy (occupancy),
        .is_empty  (is_empty),
        .is_full   (is_full)
    );

    // Queue model state
    logic [ffdo_pkg::FRAME_W-1:0]    ring_mem [MAX_SLOTS];
    int unsigned                     wr_slot;
    int unsigned                     rd_slot;
    logic [ffdo_pkg::CFG_DATA_W-1:0] slot_reg;
    logic                            drop_mode;

    status_t   pending_status [$];
    stim_row_t dir_rows [$];
    int        err_count;

    // Clock: 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("frame_fifo_drop_oldest_tb: done, errors");
        $finish;
    end

    function automatic int unsigned ring_len();
        int unsigned n;
        n = 32'(slot_reg);
        if (n < 2) n = 2;
        if (n > MAX_SLOTS) n = MAX_SLOTS;
        return n;
    endfunction

    function automatic int unsigned step_slot(int unsigned p);
        return (p + 1 >= ring_len()) ? 0 : p + 1;
    endfunction

    // Apply one command to the model and return the status it should report
    function automatic status_t apply_command(logic [1:0] cmd,
                                              logic [ffdo_pkg::FRAME_W-1:0] frame);
        status_t     s;
        int unsigned nxt;
        int unsigned cnt;
        bit          accept;
        s = '0;
        if (cmd == ffdo_pkg::CMD_PUSH)
        begin
            nxt    = step_slot(wr_slot);
            accept = 1'b1;
            if (nxt == rd_slot)
            begin
                if (drop_mode)
                begin
                    rd_slot   = step_slot(rd_slot);
                    s.dropped = 1'b1;
                end
                else
                    accept = 1'b0;
            end
            if (accept)
            begin
                ring_mem[wr_slot] = frame & FRAME_MASK[ffdo_pkg::FRAME_W-1:0];
                wr_slot           = nxt;
                s.success         = 1'b1;
            end
        end
        else if (cmd == ffdo_pkg::CMD_POP)
        begin
            if (wr_slot != rd_slot)
            begin
                s.frame   = ring_mem[rd_slot];
                rd_slot   = step_slot(rd_slot);
                s.success = 1'b1;
            end
        end
        // query and the spare code leave the state alone
        cnt = (wr_slot >= rd_slot) ? wr_slot - rd_slot : ring_len() - rd_slot + wr_slot;
        if (cnt > 255) cnt = 255;
        s.occupancy = cnt[ffdo_pkg::OCC_W-1:0];
        s.is_empty  = (wr_slot == rd_slot);
        s.is_full   = (step_slot(wr_slot) == rd_slot);
        return s;
    endfunction

    function automatic void model_write_reg(logic idx, logic [ffdo_pkg::CFG_DATA_W-1:0] val);
        if (idx == ffdo_pkg::REG_SLOT_COUNT)
        begin
            // a new ring size empties the queue
            slot_reg = val;
            wr_slot  = 0;
            rd_slot  = 0;
        end
        else
            drop_mode = val[0];
    endfunction

    function automatic status_t mk_status(logic ok, logic [ffdo_pkg::FRAME_W-1:0] f,
                                          logic d, logic [ffdo_pkg::OCC_W-1:0] o,
                                          logic e, logic fu);
        status_t s;
        s.success   = ok;
        s.frame     = f;
        s.dropped   = d;
        s.occupancy = o;
        s.is_empty  = e;
        s.is_full   = fu;
        return s;
    endfunction

    task automatic flag_error(string msg);
        err_count++;
        if (err_count <= MAX_ERR_LINES)
            $display("[%0t] mismatch: %0s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            flag_error($sformatf("%0s got %h expected %h", name, got, want));
    endtask

    // Directed table builders
    task automatic add_cmd(logic [1:0] cmd, logic [ffdo_pkg::FRAME_W-1:0] frame);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_CMD;
        r.cmd   = cmd;
        r.frame = frame;
        dir_rows.push_back(r);
    endtask

    task automatic add_typed(logic [1:0] cmd, logic [ffdo_pkg::FRAME_W-1:0] frame,
                             status_t want);
        stim_row_t r;
        r       = '0;
        r.kind  = ROW_TYPED;
        r.cmd   = cmd;
        r.frame = frame;
        r.want  = want;
        dir_rows.push_back(r);
    endtask

    task automatic add_reg(logic idx, logic [ffdo_pkg::CFG_DATA_W-1:0] val);
        stim_row_t r;
        r           = '0;
        r.kind      = ROW_REG;
        r.reg_index = idx;
        r.reg_value = val;
        dir_rows.push_back(r);
    endtask

    // Drive one command beat and record its expected status once accepted
    task automatic send_beat(logic [1:0] cmd, logic [ffdo_pkg::FRAME_W-1:0] frame,
                             bit typed, status_t want);
        status_t pred;
        @(negedge clk);
        start    <= 1'b1;
        command  <= cmd;
        frame_in <= frame;
        @(posedge clk);
        while (busy !== 1'b0) @(posedge clk);
        pred = apply_command(cmd, frame);
        pending_status.push_back(typed ? want : pred);
    endtask

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Hold off the sender until every pending status has come back
    task automatic wait_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [ffdo_pkg::CFG_DATA_W-1:0] val);
        wait_results();
        repeat (2) @(posedge clk);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        model_write_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Check each status beat against the oldest expectation
    always @(posedge clk)
    begin
        status_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_status.size() == 0)
                flag_error("status beat with nothing pending");
            else
            begin
                want = pending_status.pop_front();
                check_field("success", 32'(success), 32'(want.success));
                check_field("frame_out", frame_out, want.frame);
                check_field("dropped", 32'(dropped), 32'(want.dropped));
                check_field("occupancy", 32'(occupancy), 32'(want.occupancy));
                check_field("is_empty", 32'(is_empty), 32'(want.is_empty));
                check_field("is_full", 32'(is_full), 32'(want.is_full));
            end
        end
    end

    initial
    begin
        int          rand_sent;
        int          phase_no;
        int          phase_len;
        int          push_pct;
        int          burst_left;
        int          pick;
        int unsigned ring;
        logic [1:0]                      cmd;
        logic [ffdo_pkg::CFG_DATA_W-1:0] slot_val;
        logic                            drop_val;

        clk       = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        command   = ffdo_pkg::CMD_QUERY;
        frame_in  = '0;
        cfg_we    = 1'b0;
        cfg_index = ffdo_pkg::REG_SLOT_COUNT;
        cfg_data  = '0;
        err_count = 0;
        wr_slot   = 0;
        rd_slot   = 0;
        slot_reg  = 9'd256;
        drop_mode = 1'b0;
        foreach (ring_mem[i]) ring_mem[i] = '0;

        // Reset state, extreme frames, the spare command
        add_typed(ffdo_pkg::CMD_QUERY, 32'h0,
                  mk_status(1'b0, 32'h0, 1'b0, 8'd0, 1'b1, 1'b0));
        add_typed(ffdo_pkg::CMD_POP,   32'h0,
                  mk_status(1'b0, 32'h0, 1'b0, 8'd0, 1'b1, 1'b0));
        add_typed(ffdo_pkg::CMD_PUSH,  32'hFFFFFFFF,
                  mk_status(1'b1, 32'h0, 1'b0, 8'd1, 1'b0, 1'b0));
        add_typed(ffdo_pkg::CMD_PUSH,  32'h00000000,
                  mk_status(1'b1, 32'h0, 1'b0, 8'd2, 1'b0, 1'b0));
        add_typed(CMD_SPARE,           32'hDEADBEEF,
                  mk_status(1'b0, 32'h0, 1'b0, 8'd2, 1'b0, 1'b0));
        add_typed(ffdo_pkg::CMD_POP,   32'h0,
                  mk_status(1'b1, 32'hFFFFFFFF, 1'b0, 8'd1, 1'b0, 1'b0));
        add_typed(ffdo_pkg::CMD_POP,   32'h0,
                  mk_status(1'b1, 32'h0, 1'b0, 8'd0, 1'b1, 1'b0));
        // Smallest ring: reject on full, then drop on full
        add_reg(ffdo_pkg::REG_SLOT_COUNT, 9'd2);
        add_typed(ffdo_pkg::CMD_PUSH,  32'hA5A5A5A5,
                  mk_status(1'b1, 32'h0, 1'b0, 8'd1, 1'b0, 1'b1));
        add_typed(ffdo_pkg::CMD_PUSH,  32'h5A5A5A5A,
                  mk_status(1'b0, 32'h0, 1'b0, 8'd1, 1'b0, 1'b1));
        add_reg(ffdo_pkg::REG_DROP_OLDEST, 9'd1);
        add_typed(ffdo_pkg::CMD_PUSH,  32'h12345678,
                  mk_status(1'b1, 32'h0, 1'b1, 8'd1, 1'b0, 1'b1));
        add_typed(ffdo_pkg::CMD_POP,   32'h0,
                  mk_status(1'b1, 32'h12345678, 1'b0, 8'd0, 1'b1, 1'b0));
        add_typed(ffdo_pkg::CMD_POP,   32'h0,
                  mk_status(1'b0, 32'h0, 1'b0, 8'd0, 1'b1, 1'b0));
        // Ring sizes below and above the legal range
        add_reg(ffdo_pkg::REG_SLOT_COUNT, 9'd0);
        add_cmd(ffdo_pkg::CMD_PUSH,  32'h00000001);
        add_cmd(ffdo_pkg::CMD_PUSH,  32'h80000000);
        add_cmd(ffdo_pkg::CMD_QUERY, 32'h0);
        add_reg(ffdo_pkg::REG_SLOT_COUNT, 9'h1FF);
        add_cmd(ffdo_pkg::CMD_PUSH,  32'h7FFFFFFF);
        add_cmd(ffdo_pkg::CMD_POP,   32'h0);
        add_reg(ffdo_pkg::REG_SLOT_COUNT, 9'd1);
        add_cmd(ffdo_pkg::CMD_PUSH,  32'hC3C3C3C3);
        add_cmd(ffdo_pkg::CMD_PUSH,  32'h3C3C3C3C);
        add_cmd(ffdo_pkg::CMD_POP,   32'h0);
        add_reg(ffdo_pkg::REG_DROP_OLDEST, 9'd0);
        add_reg(ffdo_pkg::REG_SLOT_COUNT, 9'd256);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                ROW_REG:   write_reg(dir_rows[i].reg_index, dir_rows[i].reg_value);
                ROW_TYPED: send_beat(dir_rows[i].cmd, dir_rows[i].frame, 1'b1,
                                     dir_rows[i].want);
                default:   send_beat(dir_rows[i].cmd, dir_rows[i].frame, 1'b0, '0);
            endcase
        end

        // Random phases, each with its own ring size and full policy
        rand_sent = 0;
        phase_no  = 0;
        while (rand_sent < RAND_ITEMS)
        begin
            if (phase_no == 0)
            begin
                slot_val = 9'd256;
                drop_val = 1'b0;
            end
            else if (phase_no == 1)
            begin
                slot_val = 9'h1FF;
                drop_val = 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    slot_val = ffdo_pkg::CFG_DATA_W'($urandom_range(2, 9));
                else if (pick == 5)
                    slot_val = 9'd256;
                else if (pick == 6)
                    slot_val = ffdo_pkg::CFG_DATA_W'($urandom_range(257, 511));
                else if (pick == 7)
                    slot_val = ffdo_pkg::CFG_DATA_W'($urandom_range(0, 1));
                else
                    slot_val = ffdo_pkg::CFG_DATA_W'($urandom_range(10, 255));
                drop_val = 1'($urandom_range(0, 1));
            end
            write_reg(ffdo_pkg::REG_SLOT_COUNT, slot_val);
            write_reg(ffdo_pkg::REG_DROP_OLDEST,
                      {{(ffdo_pkg::CFG_DATA_W-1){1'b0}}, drop_val});

            ring = ring_len();
            if (ring >= 64)
            begin
                phase_len = 2 * ring + $urandom_range(0, 60);
                push_pct  = $urandom_range(75, 90);
            end
            else
            begin
                phase_len = $urandom_range(40, 120);
                push_pct  = $urandom_range(25, 85);
            end

            burst_left = $urandom_range(1, 30);
            for (int k = 0; k < phase_len && rand_sent < RAND_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < push_pct)  cmd = ffdo_pkg::CMD_PUSH;
                else if (pick < 95)   cmd = ffdo_pkg::CMD_POP;
                else if (pick < 98)   cmd = ffdo_pkg::CMD_QUERY;
                else                  cmd = CMD_SPARE;
                send_beat(cmd, $urandom, 1'b0, '0);
                rand_sent++;

                // end of burst: gap, or now and then let the queue drain
                burst_left--;
                if (burst_left == 0)
                begin
                    if ($urandom_range(0, 19) == 0)
                        wait_results();
                    else
                        idle_cycles($urandom_range(0, 6));
                    burst_left = $urandom_range(1, 30);
                end
            end
            phase_no++;
        end

        wait_results();
        repeat (4) @(posedge clk);
        if (pending_status.size() != 0)
            flag_error("status beats still pending at end of run");

        if (err_count == 0)
            $display("frame_fifo_drop_oldest_tb: done, clean");
        else
            $display("frame_fifo_drop_oldest_tb: done, errors");
        $finish;
    end

endmodule
